>>> hw/rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is high.
`define ASSERT_CLK(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define ASSERT_CLK_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hw/rtl/sppc_pkg.sv
package sppc_pkg;

  // fixed point of the reciprocal tables
  localparam int HSV_SHIFT = 12;
  localparam int ROUND_HALF = 1 << (HSV_SHIFT - 1);
  localparam int SAT_RECIP_W = 20;
  localparam int HUE_RECIP_W = 17;
  localparam int HUE_FULL_TURN = 180;

  localparam logic [7:0] RG_SPREAD_MIN = 8'd15;

  // register indexes
  localparam logic [2:0] REG_BLUE_MIN     = 3'd0;
  localparam logic [2:0] REG_GREEN_MIN    = 3'd1;
  localparam logic [2:0] REG_RED_MIN      = 3'd2;
  localparam logic [2:0] REG_HUE_BAND1_MAX = 3'd3;
  localparam logic [2:0] REG_HUE_BAND2_MIN = 3'd4;
  localparam logic [2:0] REG_HUE_BAND2_MAX = 3'd5;
  localparam logic [2:0] REG_SAT_MIN      = 3'd6;
  localparam logic [2:0] REG_SAT_MAX      = 3'd7;

  // register reset values
  localparam logic [7:0] RST_BLUE_MIN      = 8'd20;
  localparam logic [7:0] RST_GREEN_MIN     = 8'd40;
  localparam logic [7:0] RST_RED_MIN       = 8'd95;
  localparam logic [7:0] RST_HUE_BAND1_MAX = 8'd13;
  localparam logic [7:0] RST_HUE_BAND2_MIN = 8'd40;
  localparam logic [7:0] RST_HUE_BAND2_MAX = 8'd50;
  localparam logic [7:0] RST_SAT_MIN       = 8'd58;
  localparam logic [7:0] RST_SAT_MAX       = 8'd178;

  localparam int NUM_STAGES = 5;

  typedef struct packed {
    logic [7:0] blue_min;
    logic [7:0] green_min;
    logic [7:0] red_min;
    logic [7:0] hue_band1_max;
    logic [7:0] hue_band2_min;
    logic [7:0] hue_band2_max;
    logic [7:0] sat_min;
    logic [7:0] sat_max;
  } cfg_t;

  // after max/min extraction
  typedef struct packed {
    logic [7:0]         v;
    logic [7:0]         diff;
    logic signed [11:0] num;
    logic               rgb_ok;
  } front_t;

  // after reciprocal lookup
  typedef struct packed {
    logic [7:0]             diff;
    logic signed [11:0]     num;
    logic [SAT_RECIP_W-1:0] s_recip;
    logic [HUE_RECIP_W-1:0] h_recip;
    logic                   rgb_ok;
  } recip_t;

  // after multiply
  typedef struct packed {
    logic [27:0]        s_prod;
    logic signed [29:0] h_prod;
    logic               rgb_ok;
  } prod_t;

  // after rounding
  typedef struct packed {
    logic [7:0] hue;
    logic [7:0] sat;
    logic       rgb_ok;
  } hs_t;

  typedef struct packed {
    logic       is_skin;
    logic [7:0] hue;
    logic [7:0] sat;
  } result_t;

endpackage

>>> hw/rtl/sppc_front.sv
module sppc_front import sppc_pkg::*; (
  input  logic       clk,
  input  logic       en,
  input  logic [7:0] blue,
  input  logic [7:0] green,
  input  logic [7:0] red,
  input  cfg_t       cfg,
  output front_t     q
);

  logic [7:0]         vmax;
  logic [7:0]         vmin;
  logic [7:0]         diff;
  logic signed [11:0] num;
  logic               spread_ok;
  front_t             q_next;

  // max, min and hue numerator; red wins ties over green, green over blue
  always_comb begin
    vmax = red;
    if (green > vmax) vmax = green;
    if (blue > vmax) vmax = blue;
    vmin = red;
    if (green < vmin) vmin = green;
    if (blue < vmin) vmin = blue;
    diff = vmax - vmin;
    if (vmax == red) begin
      num = $signed({4'b0, green}) - $signed({4'b0, blue});
    end else if (vmax == green) begin
      num = $signed({4'b0, blue}) - $signed({4'b0, red}) + $signed({3'b0, diff, 1'b0});
    end else begin
      num = $signed({4'b0, red}) - $signed({4'b0, green}) + $signed({2'b0, diff, 2'b0});
    end
    spread_ok = (red > green && (red - green) > RG_SPREAD_MIN) ||
                (green > red && (green - red) > RG_SPREAD_MIN);
    q_next.v      = vmax;
    q_next.diff   = diff;
    q_next.num    = num;
    q_next.rgb_ok = (blue > cfg.blue_min) && (green > cfg.green_min) &&
                    (red > cfg.red_min) && (red > green) && (red > blue) && spread_ok;
  end

  always_ff @(posedge clk) begin
    if (en) q <= q_next;
  end

endmodule

>>> hw/rtl/sppc_recip.sv
module sppc_recip import sppc_pkg::*; (
  input  logic   clk,
  input  logic   en,
  input  front_t d,
  output recip_t q
);

  logic [SAT_RECIP_W-1:0] s_tab [256];
  logic [HUE_RECIP_W-1:0] h_tab [256];

  // rounded reciprocal tables: 255/v and 30/diff in 12 fractional bits
  for (genvar gi = 0; gi < 256; gi++) begin : g_tab
    if (gi == 0) begin : g_zero
      assign s_tab[gi] = '0;
      assign h_tab[gi] = '0;
    end else begin : g_entry
      localparam int SDen = 2 * gi;
      localparam int HDen = 12 * gi;
      localparam int SRecip = (2 * (255 << HSV_SHIFT) + gi) / SDen;
      localparam int HRecip = (2 * (HUE_FULL_TURN << HSV_SHIFT) + 6 * gi) / HDen;
      assign s_tab[gi] = SRecip[SAT_RECIP_W-1:0];
      assign h_tab[gi] = HRecip[HUE_RECIP_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q.diff    <= d.diff;
      q.num     <= d.num;
      q.s_recip <= s_tab[d.v];
      q.h_recip <= h_tab[d.diff];
      q.rgb_ok  <= d.rgb_ok;
    end
  end

endmodule

>>> hw/rtl/sppc_mul.sv
module sppc_mul import sppc_pkg::*; (
  input  logic   clk,
  input  logic   en,
  input  recip_t d,
  output prod_t  q
);

  // one unsigned and one signed product per word
  always_ff @(posedge clk) begin
    if (en) begin
      q.s_prod <= 28'(d.diff) * 28'(d.s_recip);
      q.h_prod <= 30'(d.num) * $signed({13'b0, d.h_recip});
      q.rgb_ok <= d.rgb_ok;
    end
  end

endmodule

>>> hw/rtl/sppc_round.sv
module sppc_round import sppc_pkg::*; (
  input  logic  clk,
  input  logic  en,
  input  prod_t d,
  output hs_t   q
);

  logic [27:0]        s_sum;
  logic [15:0]        s_full;
  logic signed [29:0] h_sum;
  logic signed [17:0] h_full;
  logic signed [17:0] h_wrap;
  hs_t                q_next;

  // round to nearest, wrap negative red hue, clamp to 8 bits
  always_comb begin
    s_sum  = d.s_prod + 28'(ROUND_HALF);
    s_full = s_sum[27:HSV_SHIFT];
    h_sum  = d.h_prod + 30'(ROUND_HALF);
    h_full = h_sum[29:HSV_SHIFT];
    h_wrap = h_full;
    if (h_full < 0) h_wrap = h_full + 18'(HUE_FULL_TURN);
    if (h_wrap < 0) begin
      q_next.hue = '0;
    end else if (h_wrap > 18'sd255) begin
      q_next.hue = 8'd255;
    end else begin
      q_next.hue = h_wrap[7:0];
    end
    q_next.sat    = (|s_full[15:8]) ? 8'd255 : s_full[7:0];
    q_next.rgb_ok = d.rgb_ok;
  end

  always_ff @(posedge clk) begin
    if (en) q <= q_next;
  end

endmodule

>>> hw/rtl/sppc_decide.sv
module sppc_decide import sppc_pkg::*; (
  input  logic    clk,
  input  logic    en,
  input  hs_t     d,
  input  cfg_t    cfg,
  output result_t q
);

  logic    hue_ok;
  logic    sat_ok;
  result_t q_next;

  // hue band and saturation window tests
  always_comb begin
    hue_ok = (d.hue <= cfg.hue_band1_max) ||
             (d.hue >= cfg.hue_band2_min && d.hue <= cfg.hue_band2_max);
    sat_ok = (d.sat > cfg.sat_min) && (d.sat < cfg.sat_max);
    q_next.is_skin = d.rgb_ok && hue_ok && sat_ok;
    q_next.hue     = d.hue;
    q_next.sat     = d.sat;
  end

  always_ff @(posedge clk) begin
    if (en) q <= q_next;
  end

endmodule

>>> hw/rtl/skin_pixel_classifier_core.sv
// Skin pixel classifier core.
// Input channel: in_valid/in_ready carries one BGR pixel word (blue, green, red).
// Output channel: out_valid/out_ready carries one result word per pixel:
// is_skin, hue (0..179, half degrees) and saturation (0..255).
// Config: cfg_wr_en/cfg_index/cfg_data write one 8-bit threshold register per
// cycle; write only while no pixel is in flight.
// Pipeline: five register stages (min/max, reciprocal table, multiply, round,
// classify); a result shows on the output from the classify register.
// Throughput: one pixel per cycle while out_ready is high; the multiply stage and
// the table lookup are each a single register stage, so every stage holds at most one word.
// Stall: when out_ready is low the output word holds; upstream stages keep
// filling empty slots, and in_ready drops only once every stage is full.
// Reset: empties the pipeline and loads the threshold registers with their
// default values.
module skin_pixel_classifier_core import sppc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] blue,
  input  logic [7:0] green,
  input  logic [7:0] red,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       is_skin,
  output logic [7:0] hue,
  output logic [7:0] saturation,
  input  logic       cfg_wr_en,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_data
);

  cfg_t                  cfg;
  logic [NUM_STAGES-1:0] vld;
  logic [NUM_STAGES-1:0] adv;
  front_t                s_front;
  recip_t                s_recip;
  prod_t                 s_prod;
  hs_t                   s_hs;
  result_t               s_res;

  // threshold registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.blue_min      <= RST_BLUE_MIN;
      cfg.green_min     <= RST_GREEN_MIN;
      cfg.red_min       <= RST_RED_MIN;
      cfg.hue_band1_max <= RST_HUE_BAND1_MAX;
      cfg.hue_band2_min <= RST_HUE_BAND2_MIN;
      cfg.hue_band2_max <= RST_HUE_BAND2_MAX;
      cfg.sat_min       <= RST_SAT_MIN;
      cfg.sat_max       <= RST_SAT_MAX;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_BLUE_MIN:      cfg.blue_min      <= cfg_data;
        REG_GREEN_MIN:     cfg.green_min     <= cfg_data;
        REG_RED_MIN:       cfg.red_min       <= cfg_data;
        REG_HUE_BAND1_MAX: cfg.hue_band1_max <= cfg_data;
        REG_HUE_BAND2_MIN: cfg.hue_band2_min <= cfg_data;
        REG_HUE_BAND2_MAX: cfg.hue_band2_max <= cfg_data;
        REG_SAT_MIN:       cfg.sat_min       <= cfg_data;
        REG_SAT_MAX:       cfg.sat_max       <= cfg_data;
        default: ;
      endcase
    end
  end

  // a stage loads when it is empty or its word moves on
  always_comb begin
    adv[NUM_STAGES-1] = !vld[NUM_STAGES-1] || out_ready;
    for (int i = NUM_STAGES - 2; i >= 0; i--) begin
      adv[i] = !vld[i] || adv[i+1];
    end
  end

  assign in_ready = adv[0];

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) vld[0] <= in_valid;
      for (int i = 1; i < NUM_STAGES; i++) begin
        if (adv[i]) vld[i] <= vld[i-1];
      end
    end
  end

  sppc_front u_front (
    .clk   (clk),
    .en    (adv[0] && in_valid),
    .blue  (blue),
    .green (green),
    .red   (red),
    .cfg   (cfg),
    .q     (s_front)
  );

  sppc_recip u_recip (
    .clk (clk),
    .en  (adv[1] && vld[0]),
    .d   (s_front),
    .q   (s_recip)
  );

  sppc_mul u_mul (
    .clk (clk),
    .en  (adv[2] && vld[1]),
    .d   (s_recip),
    .q   (s_prod)
  );

  sppc_round u_round (
    .clk (clk),
    .en  (adv[3] && vld[2]),
    .d   (s_prod),
    .q   (s_hs)
  );

  sppc_decide u_decide (
    .clk (clk),
    .en  (adv[4] && vld[3]),
    .d   (s_hs),
    .cfg (cfg),
    .q   (s_res)
  );

  assign out_valid  = vld[NUM_STAGES-1];
  assign is_skin    = s_res.is_skin;
  assign hue        = s_res.hue;
  assign saturation = s_res.sat;

endmodule

>>> hw/rtl/sppc_checker.sv
`include "assert_macros.svh"

module sppc_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       is_skin,
  input logic [7:0] hue,
  input logic [7:0] saturation
);

  // stalled result word holds
  `ASSERT_CLK(a_out_hold, clk, rst,
              out_valid && !out_ready |=> out_valid && $stable({is_skin, hue, saturation}),
              "output word changed while stalled")

  // reset empties the pipeline
  `ASSERT_CLK_ALWAYS(a_rst_empty, clk, rst |=> !out_valid, "output valid right after reset")

  // an empty output stage means every stage can take a pixel
  `ASSERT_CLK(a_ready_when_empty, clk, rst, !out_valid |-> in_ready, "input stalled with empty output")

  // hue stays in its half-degree range
  `ASSERT_CLK(a_hue_range, clk, rst, out_valid |-> hue <= 8'd179, "hue out of range")

  // zero saturation only for grey pixels, which have zero hue and are not skin
  `ASSERT_CLK(a_grey, clk, rst, out_valid && saturation == 8'd0 |-> hue == 8'd0 && !is_skin,
              "grey pixel with hue or skin flag")

endmodule

bind skin_pixel_classifier_core sppc_checker u_checker (.*);
